FILE: design/lru_slot_directory_defines.svh
// Assertion macros shared by the directory RTL.
`ifndef LRU_SLOT_DIRECTORY_DEFINES_SVH
`define LRU_SLOT_DIRECTORY_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define LSD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lsd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsd assertion failed");

`endif

FILE: design/lsd_pkg.sv
`timescale 1ns / 1ps

package lsd_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ACT_W     = 5;
	localparam int CMP_W     = (IDX_W > ACT_W) ? IDX_W : ACT_W;
	localparam int MAX_USE   = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
	localparam int LAYER_W   = 8;
	localparam int EXPERT_W  = 10;
	localparam int KEY_W     = LAYER_W + EXPERT_W;
	localparam int CAP_W     = 41;
	localparam int STAMP_W   = 64;
	localparam int OUTC_W    = 2;
	localparam int SIDX_W    = 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [ACT_W-1:0] ACTIVE_RESET   = ACT_W'(16);
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64'd1073741824);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_SLOTS = 8'd0,
		CFG_SLOT_CAPACITY = 8'd1
	} cfg_idx_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_HIT  = 2'd0,
		OUT_LOAD = 2'd1,
		OUT_ERR  = 2'd2
	} outcome_t;

	typedef struct packed {
		logic               run;
		logic [KEY_W-1:0]   key;
		logic               too_big;
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic               inv_found;
		logic [IDX_W-1:0]   inv_idx;
		logic               min_seen;
		logic [STAMP_W-1:0] min_stamp;
		logic [IDX_W-1:0]   min_idx;
	} tok_t;

	typedef struct packed {
		logic               en;
		logic               load;
		logic [IDX_W-1:0]   idx;
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

endpackage

FILE: design/lsd_cell.sv
`timescale 1ns / 1ps

module lsd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lsd_pkg::IDX_W-1:0]  slot_id,
	input  logic [lsd_pkg::ACT_W-1:0]  n_active,
	input  lsd_pkg::tok_t              tok_in,
	output lsd_pkg::tok_t              tok_out,
	input  lsd_pkg::wr_t               wr
);

	logic                          valid_q;
	logic [lsd_pkg::KEY_W-1:0]     key_q;
	logic [lsd_pkg::STAMP_W-1:0]   stamp_q;
	lsd_pkg::tok_t                 tok_q;
	lsd_pkg::tok_t                 tok_nxt;
	logic                          active;
	logic                          wr_me;

	assign active = lsd_pkg::CMP_W'(slot_id) < lsd_pkg::CMP_W'(n_active);
	assign wr_me  = wr.en && (wr.idx == slot_id);

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.run && active) begin
			if (valid_q && (key_q == tok_in.key) && !tok_in.hit) begin
				tok_nxt.hit     = 1'b1;
				tok_nxt.hit_idx = slot_id;
			end
			if (!valid_q && !tok_in.inv_found) begin
				tok_nxt.inv_found = 1'b1;
				tok_nxt.inv_idx   = slot_id;
			end
			if (valid_q && (!tok_in.min_seen || (stamp_q < tok_in.min_stamp))) begin
				tok_nxt.min_seen  = 1'b1;
				tok_nxt.min_stamp = stamp_q;
				tok_nxt.min_idx   = slot_id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.run <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_me) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			stamp_q <= wr.stamp;
			if (wr.load) begin
				key_q <= wr.key;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: design/lru_slot_directory.sv
`timescale 1ns / 1ps
// A request is registered into the launch register, walks the cell chain, waits in the
// finish register and is registered onto m_axis; the search token walks the
// cell chain one slot per cycle and the next request enters after the write-back.
// Reset: all slots invalid, use counter zero, active_slots 16, capacity 2^30 bytes.
// The slot keys and stamps are not reset; they are only read once written.

`include "lru_slot_directory_defines.svh"

module lru_slot_directory (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] layer_id, [17:8] expert, [58:18] page_bytes, [63:59] zero
	input  logic [63:0]                     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] outcome, [5:2] slot_index, [7:6] zero
	output logic [7:0]                      m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsd_pkg::CAP_W-1:0]       cfg_data
);

	logic [lsd_pkg::ACT_W-1:0]   active_q;
	logic [lsd_pkg::CAP_W-1:0]   cap_q;
	logic [lsd_pkg::ACT_W-1:0]   n_active;
	logic [lsd_pkg::STAMP_W-1:0] use_ctr_q;
	logic [lsd_pkg::STAMP_W-1:0] use_ctr_inc;
	logic                        busy_q;
	logic                        accept;
	logic                        commit;
	lsd_pkg::tok_t               launch_nxt;
	lsd_pkg::tok_t               launch_q;
	lsd_pkg::tok_t               fin_q;
	lsd_pkg::tok_t               tok_chain [lsd_pkg::NUM_SLOTS+1];
	logic [lsd_pkg::NUM_SLOTS+1:0] run_vec;
	lsd_pkg::wr_t                wr;
	lsd_pkg::outcome_t           outc_sel;
	logic [lsd_pkg::IDX_W-1:0]   idx_sel;
	logic                        m_valid_q;
	lsd_pkg::outcome_t           m_outc_q;
	logic [lsd_pkg::SIDX_W-1:0]  m_idx_q;
	logic [lsd_pkg::LAYER_W-1:0]  in_layer;
	logic [lsd_pkg::EXPERT_W-1:0] in_expert;
	logic [lsd_pkg::CAP_W-1:0]    in_bytes;

	assign in_layer  = s_axis_tdata[7:0];
	assign in_expert = s_axis_tdata[17:8];
	assign in_bytes  = s_axis_tdata[58:18];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign commit        = fin_q.run && (!m_valid_q || m_axis_tready);
	assign use_ctr_inc   = use_ctr_q + lsd_pkg::STAMP_W'(1);

	always_comb begin
		if (active_q == '0) begin
			n_active = lsd_pkg::ACT_W'(1);
		end else if (active_q > lsd_pkg::ACT_W'(lsd_pkg::MAX_USE)) begin
			n_active = lsd_pkg::ACT_W'(lsd_pkg::MAX_USE);
		end else begin
			n_active = active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lsd_pkg::ACTIVE_RESET;
			cap_q    <= lsd_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsd_pkg::CFG_ACTIVE_SLOTS:  active_q <= cfg_data[lsd_pkg::ACT_W-1:0];
				lsd_pkg::CFG_SLOT_CAPACITY: cap_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		launch_nxt         = '0;
		launch_nxt.run     = accept;
		launch_nxt.key     = {in_layer, in_expert};
		launch_nxt.too_big = in_bytes > cap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q.run <= 1'b0;
		end else begin
			launch_q <= launch_nxt;
		end
	end

	assign tok_chain[0] = launch_q;

	for (genvar i = 0; i < lsd_pkg::NUM_SLOTS; i++) begin : g_cell
		lsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_id  (lsd_pkg::IDX_W'(i)),
			.n_active (n_active),
			.tok_in   (tok_chain[i]),
			.tok_out  (tok_chain[i+1]),
			.wr       (wr)
		);
	end

	for (genvar i = 0; i <= lsd_pkg::NUM_SLOTS; i++) begin : g_run
		assign run_vec[i] = tok_chain[i].run;
	end
	assign run_vec[lsd_pkg::NUM_SLOTS+1] = fin_q.run;

	always_comb begin
		wr       = '0;
		wr.key   = fin_q.key;
		wr.stamp = use_ctr_inc;
		outc_sel = lsd_pkg::OUT_ERR;
		idx_sel  = '0;
		if (fin_q.hit) begin
			outc_sel = lsd_pkg::OUT_HIT;
			idx_sel  = fin_q.hit_idx;
			wr.en    = commit;
			wr.idx   = fin_q.hit_idx;
		end else if (!fin_q.too_big) begin
			outc_sel = lsd_pkg::OUT_LOAD;
			idx_sel  = fin_q.inv_found ? fin_q.inv_idx : fin_q.min_idx;
			wr.en    = commit;
			wr.load  = 1'b1;
			wr.idx   = idx_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q.run <= 1'b0;
			busy_q    <= 1'b0;
			use_ctr_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (tok_chain[lsd_pkg::NUM_SLOTS].run) begin
				fin_q <= tok_chain[lsd_pkg::NUM_SLOTS];
			end else if (commit) begin
				fin_q.run <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (wr.en) begin
				use_ctr_q <= use_ctr_inc;
			end
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_outc_q <= outc_sel;
			m_idx_q  <= lsd_pkg::SIDX_W'(idx_sel);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_idx_q, m_outc_q};

	`LSD_ASSERT_NEXT(a_one_item, accept, !s_axis_tready)
	`LSD_ASSERT_ALWAYS(a_single_token, $onehot0(run_vec))
	`LSD_ASSERT_NEXT(a_ctr_step, wr.en, use_ctr_q == $past(use_ctr_q) + lsd_pkg::STAMP_W'(1))
	`LSD_ASSERT_ALWAYS(a_err_idx, !m_valid_q || (m_outc_q != lsd_pkg::OUT_ERR) || (m_idx_q == '0))

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import lsd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = CFG_IDX_W'(2);
	localparam logic [CAP_W-1:0]     CAP_MAX          = '1;
	localparam logic [CAP_W-1:0]     CAP_TOP          = CAP_W'(64'h100_0000_0000);
	localparam int                   RANDOM_PHASES    = 7;
	localparam int                   PHASE_ITEMS      = 122;
	localparam int                   REPORT_LIMIT     = 10;

	typedef struct {
		outcome_t          outc;
		logic [SIDX_W-1:0] idx;
	} slot_result_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CAP_W-1:0]     reg_val;
		logic [LAYER_W-1:0]   layer;
		logic [EXPERT_W-1:0]  expert;
		logic [CAP_W-1:0]     page;
		bit                   typed;
		slot_result_t         want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// [7:0] layer_id, [17:8] expert, [58:18] page_bytes, [63:59] zero
	logic [63:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// [1:0] outcome, [5:2] slot_index, [7:6] zero
	logic [7:0]           m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0]     cfg_data;

	lru_slot_directory u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	bit                 dir_valid [NUM_SLOTS];
	logic [KEY_W-1:0]   dir_key   [NUM_SLOTS];
	logic [STAMP_W-1:0] dir_stamp [NUM_SLOTS];
	logic [STAMP_W-1:0] dir_clock;
	logic [ACT_W-1:0]   dir_active;
	logic [CAP_W-1:0]   dir_capacity;

	slot_result_t expected_results [$];
	slot_result_t head_result;
	int           mismatches;
	int           items_sent;
	int           reg_writes;
	int           hits;
	int           loads;
	int           oversize;
	int           burst_left;
	int           sink_wait;
	bit           sink_steady;

	function automatic int slots_searched();
		int n;
		n = (dir_active == 0) ? 1 : int'(dir_active);
		return (n > MAX_USE) ? MAX_USE : n;
	endfunction

	function automatic slot_result_t directory_lookup(logic [KEY_W-1:0] key,
			logic [CAP_W-1:0] page);
		int           n;
		int           victim;
		slot_result_t res;
		n = slots_searched();
		for (int i = 0; i < n; i++) begin
			if (dir_valid[i] && dir_key[i] == key) begin
				dir_clock = dir_clock + 1'b1;
				dir_stamp[i] = dir_clock;
				res.outc = OUT_HIT;
				res.idx = SIDX_W'(i);
				return res;
			end
		end
		victim = -1;
		for (int i = 0; i < n; i++)
			if (victim < 0 && !dir_valid[i])
				victim = i;
		if (victim < 0) begin
			victim = 0;
			for (int i = 1; i < n; i++)
				if (dir_stamp[i] < dir_stamp[victim])
					victim = i;
		end
		if (page > dir_capacity) begin
			res.outc = OUT_ERR;
			res.idx = '0;
			return res;
		end
		dir_clock = dir_clock + 1'b1;
		dir_valid[victim] = 1'b1;
		dir_key[victim] = key;
		dir_stamp[victim] = dir_clock;
		res.outc = OUT_LOAD;
		res.idx = SIDX_W'(victim);
		return res;
	endfunction

	function automatic logic [CAP_W-1:0] pick_page();
		logic [63:0] r;
		int          sel;
		r = {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return CAP_W'(r % (64'(dir_capacity) + 64'd1));
		if (sel < 65)
			return dir_capacity;
		if (sel < 75)
			return dir_capacity + 1'b1;
		if (sel < 80)
			return '0;
		return r[CAP_W-1:0];
	endfunction

	function automatic plan_row_t req_row(logic [LAYER_W-1:0] layer,
			logic [EXPERT_W-1:0] expert, logic [CAP_W-1:0] page, bit typed = 1'b0,
			outcome_t outc = OUT_HIT, logic [SIDX_W-1:0] idx = '0);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = CFG_ACTIVE_SLOTS;
		r.reg_val = '0;
		r.layer = layer;
		r.expert = expert;
		r.page = page;
		r.typed = typed;
		r.want.outc = outc;
		r.want.idx = idx;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
		plan_row_t r;
		r = req_row('0, '0, '0);
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_request(input logic [LAYER_W-1:0] layer,
			input logic [EXPERT_W-1:0] expert, input logic [CAP_W-1:0] page,
			input bit typed, input slot_result_t want);
		slot_result_t got;
		s_axis_tdata  <= {5'b0, page, expert, layer};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		got = directory_lookup({layer, expert}, page);
		case (got.outc)
			OUT_HIT:  hits++;
			OUT_LOAD: loads++;
			default:  oversize++;
		endcase
		expected_results.insert(expected_results.size(), typed ? want : got);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		s_axis_tvalid <= 1'b0;
		if ($urandom_range(0, 24) == 0)
			wait_drained();
		repeat ($urandom_range(1, 6)) @(negedge clk);
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ACTIVE_SLOTS)
			dir_active = val[ACT_W-1:0];
		else if (idx == CFG_SLOT_CAPACITY)
			dir_capacity = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (sink_wait != 0) begin
			m_axis_tready <= 1'b0;
			sink_wait <= sink_wait - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!sink_steady && $urandom_range(0, 5) == 0)
				sink_wait <= $urandom_range(1, 24);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item outcome=%0d slot=%0d",
					m_axis_tdata[1:0], m_axis_tdata[5:2]));
			end else begin
				head_result = expected_results.pop_front();
				if (m_axis_tdata[1:0] != head_result.outc)
					report_mismatch($sformatf("outcome expected %0d got %0d",
						head_result.outc, m_axis_tdata[1:0]));
				if (m_axis_tdata[5:2] != head_result.idx)
					report_mismatch($sformatf("slot_index expected %0d got %0d",
						head_result.idx, m_axis_tdata[5:2]));
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("timeout: directory stopped moving items");
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		plan_row_t          plan [22];
		slot_result_t       no_check;
		logic [KEY_W-1:0]   key_pool [$];
		logic [KEY_W-1:0]   key;
		logic [ACT_W-1:0]   cfg_active;
		logic [CAP_W-1:0]   cfg_cap;
		int                 pool_size;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		sink_wait     = 0;
		sink_steady   = 1'b0;
		burst_left    = 0;
		mismatches    = 0;
		items_sent    = 0;
		reg_writes    = 0;
		hits          = 0;
		loads         = 0;
		oversize      = 0;
		no_check.outc = OUT_HIT;
		no_check.idx  = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			dir_valid[i] = 1'b0;
			dir_key[i]   = '0;
			dir_stamp[i] = '0;
		end
		dir_clock    = '0;
		dir_active   = ACTIVE_RESET;
		dir_capacity = CAPACITY_RESET;

		plan = '{
			req_row(8'd0,   10'd0,    '0,                    1'b1, OUT_LOAD, 4'd0),
			req_row(8'd0,   10'd0,    CAP_MAX,               1'b1, OUT_HIT,  4'd0),
			req_row(8'd255, 10'd1023, CAPACITY_RESET,        1'b1, OUT_LOAD, 4'd1),
			req_row(8'd1,   10'd1,    CAPACITY_RESET + 1'b1, 1'b1, OUT_ERR,  4'd0),
			req_row(8'd1,   10'd1,    CAP_MAX,               1'b1, OUT_ERR,  4'd0),
			cfg_row(CFG_SLOT_CAPACITY, '0),
			req_row(8'd1,   10'd1,    '0,                    1'b1, OUT_LOAD, 4'd2),
			req_row(8'd1,   10'd2,    41'd1,                 1'b1, OUT_ERR,  4'd0),
			cfg_row(CFG_IDX_UNMAPPED, CAP_MAX),
			cfg_row(CFG_ACTIVE_SLOTS, '0),
			req_row(8'd255, 10'd1023, '0,                    1'b1, OUT_LOAD, 4'd0),
			req_row(8'd1,   10'd1,    '0,                    1'b1, OUT_LOAD, 4'd0),
			cfg_row(CFG_ACTIVE_SLOTS, 41'd31),
			cfg_row(CFG_SLOT_CAPACITY, CAP_MAX),
			req_row(8'd255, 10'd1023, CAP_MAX,               1'b1, OUT_HIT,  4'd1),
			req_row(8'd1,   10'd1,    41'd7),
			req_row(8'd0,   10'd0,    41'd5),
			cfg_row(CFG_ACTIVE_SLOTS, 41'd3),
			req_row(8'd170, 10'd682,  41'd9),
			req_row(8'd85,  10'd341,  CAP_TOP),
			cfg_row(CFG_ACTIVE_SLOTS, 41'd16),
			cfg_row(CFG_SLOT_CAPACITY, CAPACITY_RESET)
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].is_cfg) begin
				cfg_write(plan[r].reg_idx, plan[r].reg_val);
			end else begin
				send_request(plan[r].layer, plan[r].expert, plan[r].page, plan[r].typed,
					plan[r].want);
				pace_sender();
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					cfg_active = 5'd16;
					cfg_cap = CAPACITY_RESET;
				end
				1: begin
					cfg_active = 5'd1;
					cfg_cap = CAP_TOP;
				end
				2: begin
					cfg_active = 5'd2;
					cfg_cap = '0;
				end
				3: begin
					cfg_active = 5'd31;
					cfg_cap = CAP_MAX;
				end
				4: begin
					cfg_active = ACT_W'($urandom_range(0, 31));
					cfg_cap = CAP_W'({$urandom, $urandom});
				end
				5: begin
					cfg_active = ACT_W'($urandom_range(5, 12));
					cfg_cap = CAP_W'({$urandom, $urandom}) >> $urandom_range(0, 30);
				end
				default: begin
					cfg_active = ACTIVE_RESET;
					cfg_cap = CAPACITY_RESET;
				end
			endcase
			cfg_write(CFG_ACTIVE_SLOTS, CAP_W'(cfg_active));
			cfg_write(CFG_SLOT_CAPACITY, cfg_cap);
			if ($urandom_range(0, 1) == 1)
				cfg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_IDX_UNMAPPED)),
					CAP_W'({$urandom, $urandom}));
			sink_steady = (ph % 3 == 2);

			key_pool.delete();
			pool_size = slots_searched() + $urandom_range(1, 4);
			repeat (pool_size)
				key_pool.insert(key_pool.size(), KEY_W'($urandom_range(0, 2 ** KEY_W - 1)));

			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0)
					key = KEY_W'($urandom);
				else
					key = key_pool[$urandom_range(0, pool_size - 1)];
				send_request(key[KEY_W-1:EXPERT_W], key[EXPERT_W-1:0], pick_page(), 1'b0,
					no_check);
				pace_sender();
			end
		end

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (NUM_SLOTS + 4) @(posedge clk);

		$display("requests %0d: %0d hits, %0d loads, %0d oversize rejects",
			items_sent, hits, loads, oversize);
		$display("register writes %0d, slot counts 0..31 and capacities 0..max, %0d mismatches",
			reg_writes, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
